### rtl/core/acps_pkg.sv
package acps_pkg;

    localparam int CORDIC_STEPS = 24;

    // vector datapath, holds scaled coordinates plus cordic growth
    localparam int CW = 52;
    // angle accumulator, q24 degrees
    localparam int AW = 35;
    // q16 angles and their differences
    localparam int QW = 28;
    localparam int UW = QW - 1;

    localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;
    localparam logic signed [AW-1:0] DEG90_Q24  = AW'(64'sd1509949440);
    localparam logic signed [AW-1:0] DEG180_Q24 = AW'(64'sd3019898880);
    localparam logic signed [AW-1:0] DEG270_Q24 = AW'(64'sd4529848320);
    localparam logic signed [QW-1:0] FULL_TURN_Q16 = QW'(64'sd23592960);

    localparam logic [1:0] MODE_NEW = 2'd0;
    localparam logic [1:0] MODE_ADD = 2'd1;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_CH   = 2'd1;
    localparam logic [1:0] REG_CV   = 2'd2;
    localparam logic [1:0] REG_RAD  = 2'd3;

    localparam logic [31:0] ATAN_Q24 [32] = '{
        32'd754974720, 32'd445687602, 32'd235489089, 32'd119537938, 32'd60000934,
        32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
        32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
        32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
        32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
    };

    typedef struct packed {
        logic pvalid;
        logic sel;
        logic zzero;
        logic zpos;
        logic yzero;
        logic xzero;
        logic xneg;
        logic ypos;
        logic vxzero;
    } side_t;

endpackage

### rtl/core/angular_circle_point_select.sv
// channel | ports              | item
// --------+--------------------+---------------------------------------------
// in      | s_tvalid/s_tready  | tdata: pos_x, pos_y, pos_z; tuser: flags
// out     | m_tvalid/m_tready  | tdata: selected_out, inside_circle
// config  | cfg_wr_en          | cfg_addr selects register, cfg_wdata value
//
// one item per cycle while the output is not stalled; one stage per
// cordic iteration in each of the two vectoring passes, plus entry and four
// finishing stages.
// synchronous active-low reset clears all stage valid bits and the config registers.
// each stage holds its item only when the next one is full and held, so
// bubbles close up and a stall at the output loses nothing.
module angular_circle_point_select (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [24:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_x, pos_y, pos_z
    input  logic [1:0]  s_tuser,   // point_valid, selected_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // selected_out, inside_circle, zero fill
);
    import acps_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int T1 = 2 * N + 1;
    localparam int T2 = 2 * N + 2;
    localparam int T3 = 2 * N + 3;
    localparam int T4 = 2 * N + 4;
    localparam int S  = 2 * N + 5;

    logic [1:0]  mode_reg;
    logic [24:0] ch_reg;
    logic [23:0] cv_reg;
    logic [24:0] rad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= '0;
            ch_reg   <= '0;
            cv_reg   <= '0;
            rad_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MODE: mode_reg <= cfg_wdata[1:0];
                REG_CH:   ch_reg   <= cfg_wdata;
                REG_CV:   cv_reg   <= cfg_wdata[23:0];
                REG_RAD:  rad_reg  <= cfg_wdata;
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    logic [S-1:0] vld_reg;
    logic [S:0]   adv;
    side_t        side_reg  [S];
    side_t        side_next [S];

    assign adv[S]   = m_tready;
    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[S-1];

    genvar k;
    generate
        for (k = 0; k < S; k++) begin : g_ctl
            assign adv[k] = !vld_reg[k] || adv[k+1];
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (adv[k]) begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (adv[k]) begin
                    side_reg[k] <= side_next[k];
                end
            end
        end
    endgenerate

    // entry stage
    logic signed [31:0] in_x, in_z;
    logic signed [32:0] in_y;
    logic signed [CW-1:0] bx, by;
    logic signed [CW-1:0] p1x_reg [N+1];
    logic signed [CW-1:0] p1y_reg [N+1];
    logic signed [AW-1:0] p1a_reg [N+1];
    logic signed [31:0]   z0_reg;

    always_comb begin
        in_x = s_tdata[31:0];
        in_y = -(33'(signed'(s_tdata[63:32])));
        in_z = s_tdata[95:64];
        bx = CW'(in_x) <<< 16;
        by = CW'(in_y) <<< 16;
        side_next[0].pvalid = s_tuser[0];
        side_next[0].sel    = s_tuser[1];
        side_next[0].zzero  = (in_z == 32'sd0);
        side_next[0].zpos   = (in_z > 32'sd0);
        side_next[0].yzero  = (in_y == 33'sd0);
        side_next[0].xzero  = (in_x == 32'sd0);
        side_next[0].xneg   = in_x[31];
        side_next[0].ypos   = (in_y > 33'sd0);
        side_next[0].vxzero = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            p1x_reg[0] <= in_x[31] ? -bx : bx;
            p1y_reg[0] <= in_x[31] ? -by : by;
            p1a_reg[0] <= '0;
            z0_reg     <= in_z;
        end
    end

    // first pass, one iteration per stage; the z gain product rides along
    logic signed [CW-1:0] zs_reg [N+1];
    logic signed [63:0]   zprod;

    assign zprod = z0_reg * GAIN_Q30;

    generate
        for (k = 1; k <= N; k++) begin : g_p1
            logic signed [CW-1:0] xs, ys;
            assign xs = p1x_reg[k-1] >>> (k-1);
            assign ys = p1y_reg[k-1] >>> (k-1);
            assign side_next[k] = side_reg[k-1];
            always_ff @(posedge aclk) begin
                if (adv[k]) begin
                    if (!p1y_reg[k-1][CW-1]) begin
                        p1x_reg[k] <= p1x_reg[k-1] + ys;
                        p1y_reg[k] <= p1y_reg[k-1] - xs;
                        p1a_reg[k] <= p1a_reg[k-1] + AW'(ATAN_Q24[k-1]);
                    end else begin
                        p1x_reg[k] <= p1x_reg[k-1] - ys;
                        p1y_reg[k] <= p1y_reg[k-1] + xs;
                        p1a_reg[k] <= p1a_reg[k-1] - AW'(ATAN_Q24[k-1]);
                    end
                    if (k == 1) begin
                        zs_reg[k] <= CW'(zprod >>> 14);
                    end else begin
                        zs_reg[k] <= zs_reg[(k == 1) ? 1 : k-1];
                    end
                end
            end
        end
    endgenerate

    // second pass, vertical angle; horizontal angle settles on entry
    logic signed [CW-1:0] p2x_reg [N+1];
    logic signed [CW-1:0] p2y_reg [N+1];
    logic signed [AW-1:0] p2a_reg [N+1];
    logic signed [AW-1:0] h24_reg [N+1];
    logic signed [AW-1:0] h24_new;
    side_t                s1;

    assign s1 = side_reg[N];

    always_comb begin
        p2x_reg[0] = p1x_reg[N];
        p2y_reg[0] = zs_reg[N];
        p2a_reg[0] = '0;
        if (s1.yzero) begin
            h24_new = s1.xneg ? DEG180_Q24 : '0;
        end else if (s1.xzero) begin
            h24_new = s1.ypos ? DEG90_Q24 : DEG270_Q24;
        end else begin
            h24_new = (s1.xneg ? DEG180_Q24 : AW'(0)) + p1a_reg[N];
        end
        h24_reg[0] = h24_new;
    end

    generate
        for (k = 1; k <= N; k++) begin : g_p2
            logic signed [CW-1:0] xs, ys;
            assign xs = p2x_reg[k-1] >>> (k-1);
            assign ys = p2y_reg[k-1] >>> (k-1);
            always_comb begin
                side_next[N+k] = side_reg[N+k-1];
                if (k == 1) begin
                    side_next[N+k].vxzero = (p1x_reg[N] == '0);
                end
            end
            always_ff @(posedge aclk) begin
                if (adv[N+k]) begin
                    if (!p2y_reg[k-1][CW-1]) begin
                        p2x_reg[k] <= p2x_reg[k-1] + ys;
                        p2y_reg[k] <= p2y_reg[k-1] - xs;
                        p2a_reg[k] <= p2a_reg[k-1] + AW'(ATAN_Q24[k-1]);
                    end else begin
                        p2x_reg[k] <= p2x_reg[k-1] - ys;
                        p2y_reg[k] <= p2y_reg[k-1] + xs;
                        p2a_reg[k] <= p2a_reg[k-1] - AW'(ATAN_Q24[k-1]);
                    end
                    h24_reg[k] <= h24_reg[k-1];
                end
            end
        end
    endgenerate

    // finishing stages: round and wrap, difference, square, compare
    side_t                s2;
    logic signed [AW-1:0] v24;
    logic signed [QW-1:0] h16r, v16r, h16w;
    logic signed [QW-1:0] h16_reg, v16_reg;
    logic signed [QW-1:0] dx, dy;
    logic [UW-1:0]        ux_reg, uy_reg;
    logic [2*UW-1:0]      sqx_reg, sqy_reg;
    logic [49:0]          rr_reg;
    logic                 in_circle;
    logic                 sel_reg, inside_reg;

    assign s2 = side_reg[2*N];

    always_comb begin
        if (s2.zzero) begin
            v24 = '0;
        end else if (s2.vxzero) begin
            v24 = s2.zpos ? DEG90_Q24 : -DEG90_Q24;
        end else begin
            v24 = p2a_reg[N];
        end
        h16r = QW'((h24_reg[N] + AW'(128)) >>> 8);
        v16r = QW'((v24 + AW'(128)) >>> 8);
        if (h16r < 0) begin
            h16w = h16r + FULL_TURN_Q16;
        end else if (h16r >= FULL_TURN_Q16) begin
            h16w = h16r - FULL_TURN_Q16;
        end else begin
            h16w = h16r;
        end
        dx = h16_reg - QW'($signed({1'b0, ch_reg}));
        dy = v16_reg - QW'($signed(cv_reg));
        in_circle = (55'(sqx_reg) + 55'(sqy_reg)) < 55'(rr_reg);
    end

    generate
        for (k = T1; k <= T4; k++) begin : g_tail
            assign side_next[k] = side_reg[k-1];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (adv[T1]) begin
            h16_reg <= h16w;
            v16_reg <= v16r;
        end
        if (adv[T2]) begin
            ux_reg <= UW'(dx[QW-1] ? -dx : dx);
            uy_reg <= UW'(dy[QW-1] ? -dy : dy);
        end
        if (adv[T3]) begin
            sqx_reg <= ux_reg * ux_reg;
            sqy_reg <= uy_reg * uy_reg;
            rr_reg  <= rad_reg * rad_reg;
        end
        if (adv[T4]) begin
            if (side_reg[T3].pvalid) begin
                inside_reg <= in_circle;
                if (in_circle) begin
                    sel_reg <= (mode_reg == MODE_NEW) || (mode_reg == MODE_ADD);
                end else begin
                    sel_reg <= (mode_reg == MODE_NEW) ? 1'b0 : side_reg[T3].sel;
                end
            end else begin
                inside_reg <= 1'b0;
                sel_reg    <= side_reg[T3].sel;
            end
        end
    end

    assign m_tdata = {6'b0, inside_reg, sel_reg};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_invalid_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !side_reg[S-1].pvalid) |->
        (!m_tdata[1] && (m_tdata[0] == side_reg[S-1].sel)))
        else $error("invalid point flag altered");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg && !m_tready) |-> !s_tready)
        else $error("input taken into full pipeline");

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acps_pkg::*;

    typedef struct packed {
        logic [1:0]  flags;   // selected_in, point_valid
        logic [95:0] pos;     // pos_z, pos_y, pos_x
    } point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [24:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    point_t      pending_points[$];
    logic [1:0]  expected_flags[$];   // inside_circle, selected_out
    int          sender_idle, receiver_idle, error_count;
    bit          hold_sender;

    // shadow copy of the selection registers
    logic [1:0]  mode_q;
    logic [24:0] center_h_q, radius_q;
    logic [23:0] center_v_q;

    angular_circle_point_select u_dut (.*);

    initial forever #6 aclk = ~aclk;

    initial begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

    function automatic longint vector_angle(inout longint vx, inout longint vy);
        longint ang, xs, ys;
        ang = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx += ys; vy -= xs; ang += longint'(ATAN_Q24[i]);
            end else begin
                vx -= ys; vy += xs; ang -= longint'(ATAN_Q24[i]);
            end
        end
        return ang;
    endfunction

    function automatic logic [1:0] select_point(point_t p);
        longint x, y, z, vx, vy, base, h24, v24, h16, v16, cv, dx, dy, zs, mx, ang;
        longint unsigned ux, uy, r;
        bit in_circle, sel;
        x = longint'($signed(p.pos[31:0]));
        y = -longint'($signed(p.pos[63:32]));
        z = longint'($signed(p.pos[95:64]));
        sel = p.flags[1];
        in_circle = 1'b0;
        if (p.flags[0]) begin
            vx = x * 65536;
            vy = y * 65536;
            base = 0;
            if (x < 0) begin
                vx = -vx; vy = -vy; base = 180 * 64'sd16777216;
            end
            ang = vector_angle(vx, vy);
            if (y == 0) h24 = (x >= 0) ? 0 : 180 * 64'sd16777216;
            else if (x == 0) h24 = (y > 0) ? 90 * 64'sd16777216 : 270 * 64'sd16777216;
            else h24 = base + ang;
            if (z == 0) v24 = 0;
            else if (vx == 0) v24 = (z > 0) ? 90 * 64'sd16777216 : -90 * 64'sd16777216;
            else begin
                zs = (z * 64'sd1768195363) >>> 14;
                mx = vx;
                v24 = vector_angle(mx, zs);
            end
            h16 = (h24 + 128) >>> 8;
            while (h16 < 0) h16 += 23592960;
            while (h16 >= 23592960) h16 -= 23592960;
            v16 = (v24 + 128) >>> 8;
            cv = longint'($signed(center_v_q));
            dx = h16 - longint'(center_h_q);
            dy = v16 - cv;
            ux = (dx < 0) ? -dx : dx;
            uy = (dy < 0) ? -dy : dy;
            r = radius_q;
            in_circle = (ux * ux + uy * uy) < r * r;
            if (mode_q == MODE_NEW) sel = 1'b0;
            if (in_circle) sel = (mode_q == MODE_NEW || mode_q == MODE_ADD);
        end
        return {in_circle, sel};
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) expected_flags.push_back(select_point({s_tuser, s_tdata}));
            if (pending_points.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= sender_idle) begin
                point_t p;
                p = pending_points.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= p.pos;
                s_tuser <= p.flags;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(string what, logic [1:0] got, logic [1:0] want);
        error_count++;
        $display("mismatch %s: got %b want %b at %0t", what, got, want, $realtime);
    endtask

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_flags.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata[1:0], 2'bxx);
                end else begin
                    logic [1:0] want;
                    want = expected_flags.pop_front();
                    if (m_tdata[0] !== want[0])
                        report_mismatch("selected_out", m_tdata[1:0], want);
                    if (m_tdata[1] !== want[1])
                        report_mismatch("inside_circle", m_tdata[1:0], want);
                end
            end
            m_tready <= $urandom_range(99) >= receiver_idle;
        end
    end

    task automatic write_reg(logic [1:0] addr, logic [24:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_MODE: mode_q = value[1:0];
            REG_CH:   center_h_q = value;
            REG_CV:   center_v_q = value[23:0];
            REG_RAD:  radius_q = value;
        endcase
    endtask

    task automatic drain_all();
        wait (pending_points.size() == 0 && !s_tvalid);
        wait (expected_flags.size() == 0);
        repeat (70) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(9))
            0:       return '0;
            1:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            2, 3:    return $urandom;
            default: return 32'($signed($urandom_range(40000)) - 20000);
        endcase
    endfunction

    function automatic point_t random_point();
        point_t p;
        p.pos = {random_coord(), random_coord(), random_coord()};
        p.flags = {1'($urandom), $urandom_range(9) != 0};
        return p;
    endfunction

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             int pv, int si);
        point_t p;
        p.pos = {z, y, x};
        p.flags = {1'(si), 1'(pv)};
        pending_points.push_back(p);
    endtask

    initial begin
        mode_q = '0; center_h_q = '0; center_v_q = '0; radius_q = '0;
        error_count = 0;
        hold_sender = 1'b0;
        sender_idle = 16;
        receiver_idle = 84;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(REG_MODE, 25'(MODE_ADD));
        write_reg(REG_CH, 25'd5898240);            // 90 degrees
        write_reg(REG_CV, 25'd0);
        write_reg(REG_RAD, 25'd23592960);
        // axis points, extremes and zero vectors
        add_point(0, 0, 0, 1, 0);
        add_point(0, 0, 1024, 1, 0);
        add_point(0, 0, -1024, 1, 1);
        add_point(1024, 0, 0, 1, 0);
        add_point(-1024, 0, 0, 1, 1);
        add_point(0, 1024, 0, 1, 0);
        add_point(0, -1024, 0, 1, 1);
        add_point(-1024, 0, 5000, 1, 0);
        add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 0);
        add_point(32'h80000000, 32'h80000000, 32'h80000000, 1, 1);
        add_point(32'h7fffffff, 32'h80000000, 0, 1, 0);
        add_point(32'h80000000, 32'h7fffffff, 32'h80000000, 1, 1);
        add_point(1, -1, 1, 1, 0);
        add_point(-1, 1, -1, 1, 1);
        add_point(3000, -3000, 0, 0, 1);
        add_point(3000, -3000, 0, 0, 0);
        add_point(-7000, -2000, 1500, 1, 0);
        add_point(-7000, 2000, -1500, 1, 1);
        add_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 0);
        drain_all();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                sender_idle = 84; receiver_idle = 16;
            end else if (ph == 2) begin
                sender_idle = 0; receiver_idle = 0;
            end
            for (int k = 0; k < 4; k++) begin
                int setting;
                setting = ph * 4 + k;
                write_reg(REG_MODE, 25'((setting < 4) ? setting : $urandom_range(3)));
                case (setting)
                    0: begin
                        write_reg(REG_CH, 25'd0);
                        write_reg(REG_CV, 25'(-24'sd5898240));
                        write_reg(REG_RAD, 25'd0);
                    end
                    1: begin
                        write_reg(REG_CH, 25'd23592959);
                        write_reg(REG_CV, 25'd5898240);
                        write_reg(REG_RAD, 25'd23592960);
                    end
                    2: begin
                        // out-of-range values are used as written
                        write_reg(REG_CH, 25'h1ffffff);
                        write_reg(REG_CV, 25'h1ffffff);
                        write_reg(REG_RAD, 25'h1ffffff);
                    end
                    default: begin
                        write_reg(REG_CH, 25'($urandom_range(23592959)));
                        write_reg(REG_CV, 25'($signed($urandom_range(11796480)) - 5898240));
                        write_reg(REG_RAD, 25'($urandom_range(1000000, 6000000)));
                    end
                endcase
                for (int n = 0; n < 140; n++) pending_points.push_back(random_point());
                if (k == 1) begin
                    // hold off until the pipeline is empty, then resume
                    wait (pending_points.size() < 70);
                    hold_sender = 1'b1;
                    wait (!s_tvalid && expected_flags.size() == 0);
                    hold_sender = 1'b0;
                end
                drain_all();
            end
        end

        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
